### rtl/vcl_pkg.sv
// Shared constants, types and code values for the voxel cell lookup and step block.
`default_nettype none

package vcl_pkg;

   localparam int GRID_X = 16;
   localparam int GRID_Y = 16;
   localparam int GRID_Z = 16;
   localparam int GRID_SIZE [3] = '{GRID_X, GRID_Y, GRID_Z};
   localparam int GRID_XY_MAX = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
   localparam int GRID_MAX = (GRID_XY_MAX > GRID_Z) ? GRID_XY_MAX : GRID_Z;

   // Quotient bits of the cell index, wide enough to hold the grid size itself.
   localparam int QBITS = $clog2(GRID_MAX + 1);

   localparam int ADDR_W = 12;
   localparam int DEPTH = 1 << ADDR_W;

   localparam int OFF_W = 35;
   localparam int REM_W = 34;
   localparam int CMP_W = REM_W + QBITS;
   localparam int CEN_W = 36 + QBITS;
   localparam int AD_W = 34;
   localparam int AD_LO_W = 17;
   localparam int PROD_W = AD_W + 32;

   localparam int SQ_STEPS = 32;
   localparam int SQ_LAT = SQ_STEPS + 2;
   localparam int LOC_LAT = QBITS + 3;
   localparam int LOC_PAD = SQ_LAT - LOC_LAT;
   localparam int DIV_STEPS = 32;

   localparam logic REQ_QUERY = 1'b0;
   localparam logic REQ_LOAD = 1'b1;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_Z = 3'd5;

   typedef logic [2:0][31:0] vec3_type;
   typedef logic [2:0][30:0] half3_type;

   typedef struct packed {
      logic              valid;
      logic              load;
      vec3_type          pos;
      vec3_type          dir;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       density;
      logic [15:0]       rock;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic              load;
      logic              found;
      vec3_type          centre;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       density;
      logic [15:0]       rock;
   } meta_type;

   typedef struct packed {
      meta_type            meta;
      logic [2:0][AD_W-1:0] ad;
      vec3_type            dd;
      logic [2:0]          act;
   } loc_type;

   typedef struct packed {
      meta_type    meta;
      logic [31:0] step;
   } rslt_type;

endpackage

`default_nettype wire

### rtl/vcl_locate.sv
// Cell index, centre and boundary distance pipeline for the three axes.
`default_nettype none

module vcl_locate (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire vcl_pkg::item_type item,
   input  wire vcl_pkg::vec3_type origin,
   input  wire vcl_pkg::half3_type half,
   output vcl_pkg::loc_type       loc
);

   localparam int QB = vcl_pkg::QBITS;
   localparam int CS = QB + 1;

   vcl_pkg::item_type                item_ff [CS+1];
   logic [vcl_pkg::REM_W-1:0]        rem_ff [QB+1][3];
   logic [QB-1:0]                    q_ff [QB+1][3];
   logic                             bad_ff [QB+1][3];
   logic [vcl_pkg::CEN_W-1:0]        cen_ff [3];
   logic [QB-1:0]                    idx_ff [3];
   logic                             cbad_ff [3];
   logic [31:0]                      w [3];
   logic [31:0]                      cs_c [3];
   logic [vcl_pkg::AD_W-1:0]         ad_c [3];
   logic [31:0]                      dd_c [3];
   logic [31:0]                      lin;
   vcl_pkg::loc_type                 loc_in;
   vcl_pkg::loc_type                 loc_ff;
   vcl_pkg::loc_type                 pad_ff [vcl_pkg::LOC_PAD];

   genvar s, a, j, p;

   for (s = 0; s <= CS; s++) begin : g_item
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               item_ff[s].valid <= 1'b0;
            end else if (adv) begin
               item_ff[s] <= item;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               item_ff[s].valid <= 1'b0;
            end else if (adv) begin
               item_ff[s] <= item_ff[s-1];
            end
         end
      end
   end

   for (a = 0; a < 3; a++) begin : g_axis
      localparam int G = vcl_pkg::GRID_SIZE[a];
      logic [vcl_pkg::OFF_W-1:0] off;
      logic [QB:0]               qf;
      logic                      rng_bad;
      logic [31+QB:0]            wq;
      logic [vcl_pkg::CEN_W-1:0] cen;
      logic [vcl_pkg::CEN_W-1:0] hx;
      logic [vcl_pkg::CEN_W-1:0] bnd;
      logic [vcl_pkg::CEN_W-1:0] diff;
      logic [vcl_pkg::CEN_W-1:0] adf;
      logic [vcl_pkg::CEN_W-32:0] top;
      logic                      dneg;

      assign w[a] = {half[a], 1'b0};
      assign off = vcl_pkg::OFF_W'($signed(item.pos[a]))
                 - vcl_pkg::OFF_W'($signed(origin[a]))
                 + vcl_pkg::OFF_W'(half[a]);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[0][a] <= off[vcl_pkg::REM_W-1:0];
            bad_ff[0][a] <= off[vcl_pkg::OFF_W-1];
            q_ff[0][a]   <= '0;
         end
      end

      for (j = 1; j <= QB; j++) begin : g_step
         localparam int K = QB - j;
         logic [vcl_pkg::CMP_W-1:0] rx;
         logic [vcl_pkg::CMP_W-1:0] wsh;
         logic                      ge;
         logic                      ovf;

         assign rx = vcl_pkg::CMP_W'(rem_ff[j-1][a]);
         assign wsh = vcl_pkg::CMP_W'(w[a]) << K;
         assign ge = rx >= wsh;
         assign ovf = (j == 1) && (rx >= (vcl_pkg::CMP_W'(w[a]) << QB));

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j][a] <= ge ? vcl_pkg::REM_W'(rx - wsh) : rem_ff[j-1][a];
               q_ff[j][a]   <= QB'({q_ff[j-1][a], ge});
               bad_ff[j][a] <= bad_ff[j-1][a] | ovf;
            end
         end
      end

      // A negative direction selects the cell below the one that holds the position.
      assign qf = {1'b0, q_ff[QB][a]} - (QB+1)'(item_ff[QB].dir[a][31]);
      assign rng_bad = qf[QB] | (qf >= (QB+1)'(G));
      assign wq = w[a] * qf[QB-1:0];
      assign cen = vcl_pkg::CEN_W'($signed(origin[a])) + vcl_pkg::CEN_W'(wq);

      always_ff @(posedge clock) begin
         if (adv) begin
            cen_ff[a]  <= cen;
            idx_ff[a]  <= qf[QB-1:0];
            cbad_ff[a] <= bad_ff[QB][a] | rng_bad;
         end
      end

      assign dneg = item_ff[CS].dir[a][31];
      assign hx = vcl_pkg::CEN_W'(half[a]);
      assign bnd = dneg ? cen_ff[a] - hx : cen_ff[a] + hx;
      assign diff = bnd - vcl_pkg::CEN_W'($signed(item_ff[CS].pos[a]));
      assign adf = diff[vcl_pkg::CEN_W-1] ? -diff : diff;
      assign ad_c[a] = adf[vcl_pkg::AD_W-1:0];
      assign top = cen_ff[a][vcl_pkg::CEN_W-1:31];
      assign cs_c[a] = ((top == '0) || (top == '1)) ? cen_ff[a][31:0] :
                       (cen_ff[a][vcl_pkg::CEN_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      assign dd_c[a] = item_ff[CS].dir[a][31] ? -item_ff[CS].dir[a] : item_ff[CS].dir[a];
   end

   assign lin = 32'(idx_ff[2]) * 32'(vcl_pkg::GRID_X * vcl_pkg::GRID_Y)
              + 32'(idx_ff[1]) * 32'(vcl_pkg::GRID_X)
              + 32'(idx_ff[0]);

   always_comb begin
      loc_in.meta.valid   = item_ff[CS].valid;
      loc_in.meta.load    = item_ff[CS].load;
      loc_in.meta.found   = !(cbad_ff[0] | cbad_ff[1] | cbad_ff[2]);
      loc_in.meta.addr    = (item_ff[CS].load == vcl_pkg::REQ_LOAD) ?
                            item_ff[CS].addr : lin[vcl_pkg::ADDR_W-1:0];
      loc_in.meta.density = item_ff[CS].density;
      loc_in.meta.rock    = item_ff[CS].rock;
      for (int i = 0; i < 3; i++) begin
         loc_in.meta.centre[i] = cs_c[i];
         loc_in.ad[i]          = ad_c[i];
         loc_in.dd[i]          = dd_c[i];
         loc_in.act[i]         = |item_ff[CS].dir[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loc_ff.meta.valid <= 1'b0;
      end else if (adv) begin
         loc_ff <= loc_in;
      end
   end

   // Delay that lines the result up with the direction magnitude.
   for (p = 0; p < vcl_pkg::LOC_PAD; p++) begin : g_pad
      if (p == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               pad_ff[p].meta.valid <= 1'b0;
            end else if (adv) begin
               pad_ff[p] <= loc_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               pad_ff[p].meta.valid <= 1'b0;
            end else if (adv) begin
               pad_ff[p] <= pad_ff[p-1];
            end
         end
      end
   end

   assign loc = pad_ff[vcl_pkg::LOC_PAD-1];

endmodule

`default_nettype wire

### rtl/vcl_isqrt.sv
// Pipelined integer square root of the squared direction length, one result bit per stage.
`default_nettype none

module vcl_isqrt (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire vcl_pkg::vec3_type dir,
   output logic [31:0]            mag
);

   localparam int NS = vcl_pkg::SQ_STEPS;

   logic [63:0] sq_ff [3];
   logic [63:0] sum_ff;
   logic [63:0] v_ff [NS];
   logic [63:0] r_ff [NS];

   genvar a, i;

   for (a = 0; a < 3; a++) begin : g_sq
      logic [31:0] m;
      logic [63:0] prod;

      assign m = dir[a][31] ? -dir[a] : dir[a];
      assign prod = m * m;

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[a] <= prod;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   for (i = 0; i < NS; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] t;
      logic        ge;

      if (i == 0) begin : g_first
         assign v = sum_ff;
         assign r = '0;
      end else begin : g_next
         assign v = v_ff[i-1];
         assign r = r_ff[i-1];
      end

      assign t = r + BIT;
      assign ge = v >= t;

      always_ff @(posedge clock) begin
         if (adv) begin
            v_ff[i] <= ge ? v - t : v;
            r_ff[i] <= ge ? (r >> 1) + BIT : r >> 1;
         end
      end
   end

   assign mag = r_ff[NS-1][31:0];

endmodule

`default_nettype wire

### rtl/vcl_muldiv.sv
// Step candidate per axis as a saturating multiply and divide, then the minimum over the axes.
`default_nettype none

module vcl_muldiv (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire vcl_pkg::loc_type loc,
   input  wire logic [31:0]      mag,
   output vcl_pkg::rslt_type     rslt
);

   localparam int ND = vcl_pkg::DIV_STEPS;
   localparam int NM = ND + 3;
   localparam int HI_W = vcl_pkg::AD_W - vcl_pkg::AD_LO_W;

   vcl_pkg::meta_type          meta_ff [NM];
   logic [31:0]                dd_ff [NM][3];
   logic                       act_ff [NM][3];
   logic [vcl_pkg::AD_LO_W+31:0] plo_ff [3];
   logic [HI_W+31:0]           phi_ff [3];
   logic [vcl_pkg::PROD_W-1:0] prod_ff [3];
   logic                       sat_ff [ND+1][3];
   logic [63:0]                rem_ff [ND+1][3];
   logic [31:0]                q_ff [ND+1][3];
   logic [31:0]                cand [3];
   logic [31:0]                best;
   logic                       any;
   vcl_pkg::rslt_type          rslt_in;
   vcl_pkg::rslt_type          rslt_ff;

   genvar s, a, j;

   for (s = 0; s < NM; s++) begin : g_meta
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               meta_ff[s].valid <= 1'b0;
            end else if (adv) begin
               meta_ff[s] <= loc.meta;
               for (int i = 0; i < 3; i++) begin
                  dd_ff[s][i]  <= loc.dd[i];
                  act_ff[s][i] <= loc.act[i];
               end
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               meta_ff[s].valid <= 1'b0;
            end else if (adv) begin
               meta_ff[s] <= meta_ff[s-1];
               for (int i = 0; i < 3; i++) begin
                  dd_ff[s][i]  <= dd_ff[s-1][i];
                  act_ff[s][i] <= act_ff[s-1][i];
               end
            end
         end
      end
   end

   for (a = 0; a < 3; a++) begin : g_axis
      always_ff @(posedge clock) begin
         if (adv) begin
            plo_ff[a]  <= loc.ad[a][vcl_pkg::AD_LO_W-1:0] * mag;
            phi_ff[a]  <= loc.ad[a][vcl_pkg::AD_W-1:vcl_pkg::AD_LO_W] * mag;
            prod_ff[a] <= vcl_pkg::PROD_W'(plo_ff[a])
                        + (vcl_pkg::PROD_W'(phi_ff[a]) << vcl_pkg::AD_LO_W);
            sat_ff[0][a] <= prod_ff[a] >= (vcl_pkg::PROD_W'(dd_ff[1][a]) << 32);
            rem_ff[0][a] <= prod_ff[a][63:0];
            q_ff[0][a]   <= '0;
         end
      end

      for (j = 1; j <= ND; j++) begin : g_step
         localparam int K = ND - j;
         logic [63:0] dsh;
         logic        ge;

         assign dsh = 64'(dd_ff[j+1][a]) << K;
         assign ge = rem_ff[j-1][a] >= dsh;

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j][a] <= ge ? rem_ff[j-1][a] - dsh : rem_ff[j-1][a];
               q_ff[j][a]   <= {q_ff[j-1][a][30:0], ge};
               sat_ff[j][a] <= sat_ff[j-1][a];
            end
         end
      end

      assign cand[a] = sat_ff[ND][a] ? 32'hFFFF_FFFF : q_ff[ND][a];
   end

   always_comb begin
      best = 32'hFFFF_FFFF;
      any = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (act_ff[NM-1][i] && (cand[i] < best)) begin
            best = cand[i];
         end
         any = any | act_ff[NM-1][i];
      end
      rslt_in.meta = meta_ff[NM-1];
      rslt_in.step = any ? best : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rslt_ff.meta.valid <= 1'b0;
      end else if (adv) begin
         rslt_ff <= rslt_in;
      end
   end

   assign rslt = rslt_ff;

endmodule

`default_nettype wire

### rtl/voxel_cell_lookup_and_step.sv
// Top level of the voxel cell lookup and ray step block with registers, cell memory and output.
//
//   Channel   Direction  Handshake               Contents
//   req       in         req_valid / req_stall   query position and direction, or cell load
//   rsp       out        rsp_valid / rsp_stall   status, cell centre, density, rock, step
//   csr       in         csr_write               origin and half width registers
//
// One transfer can enter in every cycle while the result is not stalled, and each passes
// through the input register, the square root, the multiply, 32-step divide and minimum,
// and the output register holding the registered cell memory read.
// Reset is synchronous; the cell memory is not cleared, and a cell must be loaded before
// it is queried. A stalled result freezes the whole pipeline, while an empty input
// register still takes one transfer.
`default_nettype none

module voxel_cell_lookup_and_step (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_type,
   input  wire logic signed [31:0]                req_pos_x,
   input  wire logic signed [31:0]                req_pos_y,
   input  wire logic signed [31:0]                req_pos_z,
   input  wire logic signed [31:0]                req_dir_x,
   input  wire logic signed [31:0]                req_dir_y,
   input  wire logic signed [31:0]                req_dir_z,
   input  wire logic [vcl_pkg::ADDR_W-1:0]        req_cell_index,
   input  wire logic [31:0]                       req_load_density,
   input  wire logic [15:0]                       req_load_rock,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_status,
   output logic signed [31:0]                     rsp_centre_x,
   output logic signed [31:0]                     rsp_centre_y,
   output logic signed [31:0]                     rsp_centre_z,
   output logic [31:0]                            rsp_cell_density,
   output logic [15:0]                            rsp_cell_rock,
   output logic [31:0]                            rsp_step_length,
   input  wire logic                              csr_write,
   input  wire logic [vcl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                       csr_data
);

   typedef struct packed {
      logic [31:0] density;
      logic [15:0] rock;
   } cell_type;

   vcl_pkg::vec3_type  origin_ff;
   vcl_pkg::half3_type half_ff;
   vcl_pkg::half3_type half_eff;
   vcl_pkg::item_type  s0_ff;
   vcl_pkg::item_type  s0_in;
   vcl_pkg::loc_type   loc;
   vcl_pkg::rslt_type  rslt;
   logic [31:0]        mag;
   logic               adv;
   logic               capture;
   logic               qok;
   cell_type           mem [vcl_pkg::DEPTH];
   cell_type           rd_ff;
   logic               rsp_valid_ff;
   logic               status_ff;
   logic               show_ff;
   vcl_pkg::vec3_type  centre_ff;
   logic [31:0]        step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            half_ff[i] <= 31'd65536;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            vcl_pkg::CSR_ORIGIN_X: origin_ff[0] <= csr_data;
            vcl_pkg::CSR_ORIGIN_Y: origin_ff[1] <= csr_data;
            vcl_pkg::CSR_ORIGIN_Z: origin_ff[2] <= csr_data;
            vcl_pkg::CSR_HALF_X:   half_ff[0] <= csr_data[30:0];
            vcl_pkg::CSR_HALF_Y:   half_ff[1] <= csr_data[30:0];
            vcl_pkg::CSR_HALF_Z:   half_ff[2] <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // A half width of zero behaves as a half width of one.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         half_eff[i] = (half_ff[i] == '0) ? 31'd1 : half_ff[i];
      end
   end

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign capture = adv || !s0_ff.valid;
   assign req_stall = s0_ff.valid && !adv;

   always_comb begin
      s0_in.valid   = req_valid;
      s0_in.load    = req_type;
      s0_in.pos     = {req_pos_z, req_pos_y, req_pos_x};
      s0_in.dir     = {req_dir_z, req_dir_y, req_dir_x};
      s0_in.addr    = req_cell_index;
      s0_in.density = req_load_density;
      s0_in.rock    = req_load_rock;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (capture) begin
         s0_ff <= s0_in;
      end
   end

   vcl_locate u_locate (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .item   (s0_ff),
      .origin (origin_ff),
      .half   (half_eff),
      .loc    (loc)
   );

   vcl_isqrt u_isqrt (
      .clock (clock),
      .adv   (adv),
      .dir   (s0_ff.dir),
      .mag   (mag)
   );

   vcl_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .loc   (loc),
      .mag   (mag),
      .rslt  (rslt)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         if (rslt.meta.valid && (rslt.meta.load == vcl_pkg::REQ_LOAD)) begin
            mem[rslt.meta.addr] <= {rslt.meta.density, rslt.meta.rock};
         end
         rd_ff <= mem[rslt.meta.addr];
      end
   end

   assign qok = (rslt.meta.load == vcl_pkg::REQ_QUERY) && rslt.meta.found;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rslt.meta.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= ((rslt.meta.load == vcl_pkg::REQ_QUERY) && !rslt.meta.found) ?
                      vcl_pkg::STATUS_NOT_FOUND : vcl_pkg::STATUS_OK;
         show_ff   <= qok;
         centre_ff <= qok ? rslt.meta.centre : '0;
         step_ff   <= qok ? rslt.step : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_centre_x     = centre_ff[0];
   assign rsp_centre_y     = centre_ff[1];
   assign rsp_centre_z     = centre_ff[2];
   assign rsp_cell_density = show_ff ? rd_ff.density : '0;
   assign rsp_cell_rock    = show_ff ? rd_ff.rock : '0;
   assign rsp_step_length  = step_ff;

endmodule

`default_nettype wire

### tb/voxel_cell_lookup_and_step_test.sv
// Self-checking testbench for the voxel cell lookup and ray step block.
`timescale 1ns / 100ps

module voxel_cell_lookup_and_step_test;
   import vcl_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic              kind;
      vec3_type          pos;
      vec3_type          dir;
      logic [ADDR_W-1:0] index;
      logic [31:0]       density;
      logic [15:0]       rock;
   } cell_req_type;

   typedef struct {
      logic        status;
      vec3_type    centre;
      logic [31:0] density;
      logic [15:0] rock;
      logic [31:0] step;
   } cell_rsp_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_type;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [31:0] req_dir_x, req_dir_y, req_dir_z;
   logic [ADDR_W-1:0] req_cell_index;
   logic [31:0] req_load_density;
   logic [15:0] req_load_rock;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_status;
   logic signed [31:0] rsp_centre_x, rsp_centre_y, rsp_centre_z;
   logic [31:0] rsp_cell_density;
   logic [15:0] rsp_cell_rock;
   logic [31:0] rsp_step_length;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_data;

   longint      origin_reg [3];
   logic [30:0] half_reg [3];
   logic [31:0] density_mem [DEPTH];
   logic [15:0] rock_mem [DEPTH];
   bit          cell_loaded [DEPTH];

   cell_rsp_type expected_rsps [$];
   int error_count = 0;
   int query_count = 0;
   int load_count = 0;
   int miss_count = 0;
   int phase_count = 0;
   bit send_gaps = 1;
   bit recv_gaps = 1;
   int hold_requests = 0;
   int idle_cycles = 0;

   voxel_cell_lookup_and_step u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .req_cell_index(req_cell_index), .req_load_density(req_load_density),
      .req_load_rock(req_load_rock),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_centre_x(rsp_centre_x), .rsp_centre_y(rsp_centre_y),
      .rsp_centre_z(rsp_centre_z), .rsp_cell_density(rsp_cell_density),
      .rsp_cell_rock(rsp_cell_rock), .rsp_step_length(rsp_step_length),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint half_width(int a);
      return (half_reg[a] == 0) ? 64'sd1 : longint'(half_reg[a]);
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Finds the cell hit by a query; returns 0 when any axis leaves the grid.
   function automatic logic locate_cell(input vec3_type pos, input vec3_type dir,
                                        output longint cen [3],
                                        output logic [ADDR_W-1:0] addr);
      int gsz [3];
      longint idx [3];
      longint h, w, off, q;
      gsz = '{GRID_X, GRID_Y, GRID_Z};
      addr = '0;
      for (int a = 0; a < 3; a++) begin
         h = half_width(a);
         w = 2 * h;
         off = longint'($signed(pos[a])) - (origin_reg[a] - h);
         q = off / w;
         if (off % w != 0 && off < 0) q--;
         if ($signed(dir[a]) < 0) q--;
         if (q < 0 || q >= gsz[a]) return 1'b0;
         idx[a] = q;
         cen[a] = origin_reg[a] + w * q;
      end
      addr = ADDR_W'(idx[2] * GRID_X * GRID_Y + idx[1] * GRID_X + idx[0]);
      return 1'b1;
   endfunction

   function automatic cell_rsp_type predict_cell_rsp(cell_req_type it);
      cell_rsp_type r;
      longint cen [3];
      logic [ADDR_W-1:0] addr;
      logic [63:0] sumsq, mag, m, ad, dd;
      logic [127:0] prod;
      logic [63:0] cand, best;
      longint d, bnd, diff;
      bit any;
      r = '{status: STATUS_OK, centre: '0, density: '0, rock: '0, step: '0};
      if (it.kind == REQ_LOAD) begin
         density_mem[it.index] = it.density;
         rock_mem[it.index] = it.rock;
         cell_loaded[it.index] = 1'b1;
         return r;
      end
      if (!locate_cell(it.pos, it.dir, cen, addr)) begin
         r.status = STATUS_NOT_FOUND;
         return r;
      end
      for (int a = 0; a < 3; a++) begin
         if (cen[a] > 64'sd2147483647) r.centre[a] = 32'h7FFFFFFF;
         else if (cen[a] < -64'sd2147483648) r.centre[a] = 32'h80000000;
         else r.centre[a] = cen[a][31:0];
      end
      r.density = density_mem[addr];
      r.rock = rock_mem[addr];
      sumsq = '0;
      for (int a = 0; a < 3; a++) begin
         d = longint'($signed(it.dir[a]));
         m = (d < 0) ? -d : d;
         sumsq += m * m;
      end
      mag = root_floor(sumsq);
      best = 64'hFFFFFFFF;
      any = 1'b0;
      for (int a = 0; a < 3; a++) begin
         d = longint'($signed(it.dir[a]));
         if (d == 0) continue;
         any = 1'b1;
         bnd = cen[a] + ((d > 0) ? half_width(a) : -half_width(a));
         diff = bnd - longint'($signed(it.pos[a]));
         ad = (diff < 0) ? -diff : diff;
         dd = (d < 0) ? -d : d;
         prod = {64'd0, ad} * {64'd0, mag};
         if (prod >= ({64'd0, dd} << 32)) cand = 64'hFFFFFFFF;
         else cand = 64'(prod / {64'd0, dd});
         if (cand < best) best = cand;
      end
      r.step = any ? best[31:0] : 32'd0;
      return r;
   endfunction

   task automatic send_item(cell_req_type it);
      @(negedge clock);
      while (send_gaps && $urandom_range(99) < 33) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_type = it.kind;
      {req_pos_z, req_pos_y, req_pos_x} = it.pos;
      {req_dir_z, req_dir_y, req_dir_x} = it.dir;
      req_cell_index = it.index;
      req_load_density = it.density;
      req_load_rock = it.rock;
      req_valid = 1'b1;
      expected_rsps.push_back(predict_cell_rsp(it));
      if (it.kind == REQ_LOAD) load_count++;
      else query_count++;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic cell_req_type make_load(logic [ADDR_W-1:0] index);
      cell_req_type it;
      it.kind = REQ_LOAD;
      it.pos = {$urandom, $urandom, $urandom};
      it.dir = {$urandom, $urandom, $urandom};
      it.index = index;
      it.density = $urandom;
      it.rock = 16'($urandom);
      return it;
   endfunction

   // A query whose cell was never loaded gets a load of that cell first.
   task automatic send_query(vec3_type pos, vec3_type dir);
      cell_req_type it;
      longint cen [3];
      logic [ADDR_W-1:0] addr;
      if (locate_cell(pos, dir, cen, addr)) begin
         if (!cell_loaded[addr]) send_item(make_load(addr));
      end else begin
         miss_count++;
      end
      it = make_load('0);
      it.kind = REQ_QUERY;
      it.pos = pos;
      it.dir = dir;
      send_item(it);
   endtask

   function automatic logic [31:0] random_dir_component();
      int pick;
      logic [31:0] v;
      pick = $urandom_range(99);
      if (pick < 12) return 32'd0;
      if (pick < 55) v = $urandom_range(32'h30000, 1);
      else if (pick < 65) v = $urandom_range(3, 1);
      else return $urandom;
      return $urandom_range(1) ? -v : v;
   endfunction

   function automatic vec3_type inside_pos(vec3_type dir);
      vec3_type pos;
      longint h, w, base, off, p;
      for (int a = 0; a < 3; a++) begin
         h = half_width(a);
         w = 2 * h;
         case ($urandom_range(5))
            0: off = 0;
            1: off = w - 1;
            default: off = longint'({$urandom, $urandom} & 64'h7FFFFFFFFFFFFFFF) % w;
         endcase
         base = origin_reg[a] - h
                + w * ($urandom_range(15) + (($signed(dir[a]) < 0) ? 1 : 0));
         p = base + off;
         if (p > 64'sd2147483647 || p < -64'sd2147483648) pos[a] = $urandom;
         else pos[a] = p[31:0];
      end
      return pos;
   endfunction

   // Sends about count items, the loads that precede fresh cells included.
   task automatic random_items(int count);
      vec3_type dir;
      int start;
      start = load_count + query_count;
      while (load_count + query_count - start < count) begin
         if ($urandom_range(99) < 20) begin
            send_item(make_load(ADDR_W'($urandom)));
         end else begin
            dir = {random_dir_component(), random_dir_component(), random_dir_component()};
            if ($urandom_range(99) < 75) send_query(inside_pos(dir), dir);
            else send_query({$urandom, $urandom, $urandom}, dir);
         end
      end
   endtask

   task automatic release_input();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_for_drain();
      release_input();
      wait (expected_rsps.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      if (index < CSR_HALF_X) origin_reg[index] = longint'($signed(value));
      else half_reg[index - CSR_HALF_X] = value[30:0];
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
      wait_for_drain();
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_HALF_X, hx);
      write_reg(CSR_HALF_Y, hy);
      write_reg(CSR_HALF_Z, hz);
      phase_count++;
   endtask

   task automatic test_directed();
      cell_req_type it;
      it = make_load('0);
      it.density = 32'h0;
      it.rock = 16'h0;
      send_item(it);
      it = make_load(ADDR_W'(DEPTH - 1));
      it.density = 32'hFFFFFFFF;
      it.rock = 16'hFFFF;
      send_item(it);
      // First and last cell on the default grid, the lower x edge, then z and y leaving the grid.
      send_query({32'h0, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h10000});
      send_query({32'h1E8000, 32'h1E8000, 32'h1E8000}, {32'h10000, 32'h10000, 32'h10000});
      send_query({32'h0, 32'h0, 32'hFFFF0000}, {32'h0, 32'h0, 32'h10000});
      send_query({32'h200000, 32'h0, 32'h0}, {32'h0, 32'h0, 32'h10000});
      send_query({32'h0, 32'h210000, 32'h0}, {32'h0, 32'h0, 32'h10000});
      // A position on a cell boundary travelling backward falls in the lower cell.
      send_query({32'h30000, 32'h30000, 32'h30000}, {32'hFFFF0000, 32'h10000, 32'h0});
      send_query({32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000},
                 {32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000});
      // Zero direction gives a zero step.
      send_query({32'h50000, 32'h60000, 32'h70000}, {32'h0, 32'h0, 32'h0});
      // Extreme positions and directions, and a tiny direction component that saturates its axis candidate.
      send_query({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
                 {32'h80000000, 32'h80000000, 32'h80000000});
      send_query({32'h8000, 32'h8000, 32'h8000}, {32'h80000000, 32'h7FFFFFFF, 32'h80000000});
      send_query({32'h12345, 32'h54321, 32'hABCDE}, {32'h1, 32'h0, 32'h0});
      send_query({32'h12345, 32'h54321, 32'hABCDE}, {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1});
      send_query({32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, {32'h1, 32'h1, 32'h1});
   endtask

   task automatic test_grid_settings();
      // Zero half width acts as the smallest width.
      set_grid(32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0);
      random_items(120);
      set_grid(32'h80000000, 32'h80000000, 32'h80000000,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      random_items(120);
      set_grid(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h1, 32'h40000000, 32'h1);
      random_items(120);
      set_grid($urandom_range(32'h100000), -$urandom_range(32'h100000),
               $urandom_range(32'h100000), $urandom_range(32'h40000, 32'h4000),
               $urandom_range(32'h40000, 32'h4000), $urandom_range(32'h40000, 32'h4000));
      random_items(120);
   endtask

   task automatic test_steady_stream();
      set_grid(32'hFFF80000, 32'h00040000, 32'h0, 32'h8000, 32'h10000, 32'h20000);
      send_gaps = 0;
      recv_gaps = 0;
      random_items(150);
      send_gaps = 1;
      recv_gaps = 1;
   endtask

   task automatic test_output_hold();
      send_gaps = 0;
      hold_requests++;
      random_items(80);
      send_gaps = 1;
   endtask

   task automatic test_drain_pause();
      random_items(20);
      release_input();
      wait (expected_rsps.size() == 0);
      random_items(20);
   endtask

   task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s mismatch: expected %h, actual %h", name, expv, actv);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      cell_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result transfer with no expected result pending");
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            check_field("status", 32'(e.status), 32'(rsp_status));
            check_field("centre_x", e.centre[0], rsp_centre_x);
            check_field("centre_y", e.centre[1], rsp_centre_y);
            check_field("centre_z", e.centre[2], rsp_centre_z);
            check_field("cell_density", e.density, rsp_cell_density);
            check_field("cell_rock", 32'(e.rock), 32'(rsp_cell_rock));
            check_field("step_length", e.step, rsp_step_length);
         end
      end
   end

   initial begin
      int served;
      int hold_left;
      served = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests > served) begin
            served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = recv_gaps && ($urandom_range(99) < 33);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_QUERY;
      {req_pos_x, req_pos_y, req_pos_z} = '0;
      {req_dir_x, req_dir_y, req_dir_z} = '0;
      req_cell_index = '0;
      req_load_density = '0;
      req_load_rock = '0;
      csr_write = 1'b0;
      csr_index = CSR_ORIGIN_X;
      csr_data = '0;
      for (int a = 0; a < 3; a++) begin
         origin_reg[a] = 0;
         half_reg[a] = 31'd65536;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      random_items(100);
      test_grid_settings();
      test_steady_stream();
      test_output_hold();
      test_drain_pause();
      wait_for_drain();
      $display("Covered %0d queries (%0d outside the grid) and %0d loads", query_count,
               miss_count, load_count);
      $display("over %0d register settings, with output holds and sender pauses.",
               phase_count + 1);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
